// ===== design/rau_pkg.sv =====
package rau_pkg;

    localparam int OPND_W = 16;
    localparam int PROD_W = 2 * OPND_W;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 31;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [OPND_W-1:0] a_num;
        logic signed [OPND_W-1:0] a_den;
        logic signed [OPND_W-1:0] b_num;
        logic signed [OPND_W-1:0] b_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    err;
    } t_rau_out;

endpackage

// ===== design/rational_arith_unit.sv =====
// Exact add, subtract, multiply and divide of two signed fractions, with the result
// reduced to lowest terms, the sign on the numerator and a positive denominator (zero
// is 0/1). An item is taken when start is high and busy is low; unless it is in error,
// busy then stays high until the result has been written. The result is shown for one
// cycle with o_valid and cannot be held off. An item with a zero denominator, or a
// division by a zero fraction, gives 0/1 with err set on the cycle after it is taken,
// and busy does not rise for it. Otherwise a multiply or a divide forms the 32-bit
// denominator product and then the numerator product; add and subtract go on to a third
// multiply and the add, and the add is done again when it must swap its terms. The
// binary greatest common divisor loop follows, its length depending on the data, and
// the common factors of two are then shifted back one per cycle. Two restoring
// divisions divide the numerator and the denominator by that divisor, and o_valid rises
// as busy falls. The multiplies share one 16 by 16 multiplier, and all of the adding,
// comparing and dividing goes through one shared add/subtract unit. A zero numerator
// returns 0/1 from the check after the products (and the add, for add and subtract).
module rational_arith_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  rau_pkg::t_rau_in  i_data,
    output logic              busy,
    output logic              o_valid,
    output rau_pkg::t_rau_out o_data
);
    import rau_pkg::*;

    localparam int W  = OPND_W;
    localparam int MW = PROD_W;
    localparam int CW = $clog2(MW + 1);
    localparam int XW = MW + NUM_W + DEN_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MDEN  = 4'd1;
    localparam logic [3:0] S_MNUM  = 4'd2;
    localparam logic [3:0] S_MNUM2 = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_GSH   = 4'd7;
    localparam logic [3:0] S_DIVN  = 4'd8;
    localparam logic [3:0] S_DIVD  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    function automatic logic [W-1:0] mag_of(input logic signed [W-1:0] x);
        logic [W-1:0] m;
        begin
            m = x[W-1] ? W'(-x) : W'(x);
            return m;
        end
    endfunction

    logic [3:0]    r_state, n_state;
    logic          r_valid, n_valid;
    t_rau_out      r_out, n_out;
    logic [1:0]    r_op, n_op;
    logic [W-1:0]  r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic          r_an_s, n_an_s, r_ad_s, n_ad_s, r_bn_s, n_bn_s, r_bd_s, n_bd_s;
    logic [MW-1:0] r_num, n_num, r_den, n_den, r_u, n_u, r_v, n_v;
    logic          r_num_neg, n_num_neg, r_den_neg, n_den_neg, r_u_neg, n_u_neg;
    logic [CW-1:0] r_k, n_k, r_cnt, n_cnt;

    // Shared multiplier and shared add/subtract unit.
    logic [W-1:0]  mul_a, mul_b;
    logic [MW-1:0] prod;
    logic [MW:0]   add_a, add_b;
    logic          add_inv;
    logic [MW+1:0] sum;
    logic          borrow;

    logic          in_err;
    logic [MW:0]   rem_sh;
    logic          q_bit;
    logic [XW-1:0] q_num_ext, q_den_ext;
    logic [NUM_W-1:0] q_num;

    assign prod   = MW'(mul_a) * MW'(mul_b);
    assign sum    = {1'b0, add_a} + {1'b0, (add_inv ? ~add_b : add_b)} + (MW+2)'(add_inv);
    assign borrow = add_inv & ~sum[MW+1];
    assign q_bit  = ~borrow;

    assign in_err = (i_data.a_den == '0) || (i_data.b_den == '0)
                    || ((i_data.op == OP_DIV) && (i_data.b_num == '0));

    assign q_num_ext = XW'(r_num);
    assign q_den_ext = XW'(r_den);
    assign q_num     = q_num_ext[NUM_W-1:0];

    always_comb begin
        rem_sh = '0;
        mul_a  = r_an;
        mul_b  = r_bd;
        add_a  = '0;
        add_b  = '0;
        add_inv = 1'b1;
        case (r_state)
            S_MDEN: begin
                mul_a = r_ad;
                mul_b = (r_op == OP_DIV) ? r_bn : r_bd;
            end
            S_MNUM: begin
                mul_a = r_an;
                mul_b = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            S_MNUM2: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            S_ADD: begin
                add_a   = {1'b0, r_num};
                add_b   = {1'b0, r_u};
                add_inv = (r_num_neg != r_u_neg);
            end
            S_GCD: begin
                add_a = {1'b0, r_u};
                add_b = {1'b0, r_v};
            end
            S_DIVN: begin
                rem_sh = {r_u, r_num[MW-1]};
                add_a  = rem_sh;
                add_b  = {1'b0, r_v};
            end
            S_DIVD: begin
                rem_sh = {r_u, r_den[MW-1]};
                add_a  = rem_sh;
                add_b  = {1'b0, r_v};
            end
            default: begin
                add_inv = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_out     = r_out;
        n_op      = r_op;
        n_an      = r_an;
        n_ad      = r_ad;
        n_bn      = r_bn;
        n_bd      = r_bd;
        n_an_s    = r_an_s;
        n_ad_s    = r_ad_s;
        n_bn_s    = r_bn_s;
        n_bd_s    = r_bd_s;
        n_num     = r_num;
        n_den     = r_den;
        n_u       = r_u;
        n_v       = r_v;
        n_num_neg = r_num_neg;
        n_den_neg = r_den_neg;
        n_u_neg   = r_u_neg;
        n_k       = r_k;
        n_cnt     = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (in_err) begin
                        n_out.res_num = '0;
                        n_out.res_den = DEN_W'(1);
                        n_out.err     = 1'b1;
                        n_valid       = 1'b1;
                    end else begin
                        n_op    = i_data.op;
                        n_an    = mag_of(i_data.a_num);
                        n_ad    = mag_of(i_data.a_den);
                        n_bn    = mag_of(i_data.b_num);
                        n_bd    = mag_of(i_data.b_den);
                        n_an_s  = i_data.a_num[W-1];
                        n_ad_s  = i_data.a_den[W-1];
                        n_bn_s  = i_data.b_num[W-1];
                        n_bd_s  = i_data.b_den[W-1];
                        n_state = S_MDEN;
                    end
                end
            end
            S_MDEN: begin
                n_den     = prod;
                n_den_neg = r_ad_s ^ ((r_op == OP_DIV) ? r_bn_s : r_bd_s);
                n_state   = S_MNUM;
            end
            S_MNUM: begin
                n_num     = prod;
                n_num_neg = r_an_s ^ ((r_op == OP_MUL) ? r_bn_s : r_bd_s);
                n_state   = ((r_op == OP_ADD) || (r_op == OP_SUB)) ? S_MNUM2 : S_CHK;
            end
            S_MNUM2: begin
                n_u     = prod;
                n_u_neg = r_bn_s ^ r_ad_s ^ (r_op == OP_SUB);
                n_state = S_ADD;
            end
            S_ADD: begin
                // With opposite signs and the second term larger, swap and try again.
                if (borrow) begin
                    n_num     = r_u;
                    n_u       = r_num;
                    n_num_neg = r_u_neg;
                    n_u_neg   = r_num_neg;
                end else begin
                    n_num   = sum[MW-1:0];
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_num == '0) begin
                    n_out.res_num = '0;
                    n_out.res_den = DEN_W'(1);
                    n_out.err     = 1'b0;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_u     = r_num;
                    n_v     = r_den;
                    n_k     = '0;
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                // Binary GCD: the answer is v times two to the power k once u is zero.
                if (r_u == '0) begin
                    n_state = S_GSH;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + CW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (borrow) begin
                    n_u = r_v;
                    n_v = r_u;
                end else begin
                    n_u = sum[MW-1:0] >> 1;
                end
            end
            S_GSH: begin
                if (r_k != '0) begin
                    n_v = r_v << 1;
                    n_k = r_k - CW'(1);
                end else begin
                    n_u     = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end
            end
            S_DIVN: begin
                n_u   = q_bit ? sum[MW-1:0] : rem_sh[MW-1:0];
                n_num = {r_num[MW-2:0], q_bit};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_u     = '0;
                    n_cnt   = '0;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                n_u   = q_bit ? sum[MW-1:0] : rem_sh[MW-1:0];
                n_den = {r_den[MW-2:0], q_bit};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_out.res_num = (r_num_neg != r_den_neg) ? -q_num : q_num;
                n_out.res_den = q_den_ext[DEN_W-1:0];
                n_out.err     = 1'b0;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_op      <= n_op;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_an_s    <= n_an_s;
        r_ad_s    <= n_ad_s;
        r_bn_s    <= n_bn_s;
        r_bd_s    <= n_bd_s;
        r_num     <= n_num;
        r_den     <= n_den;
        r_u       <= n_u;
        r_v       <= n_v;
        r_num_neg <= n_num_neg;
        r_den_neg <= n_den_neg;
        r_u_neg   <= n_u_neg;
        r_k       <= n_k;
        r_cnt     <= n_cnt;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import rau_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  LIMIT_CYCLES  = 1_000_000;
    localparam int  DRAIN_CYCLES  = 400;
    localparam int  RANDOM_ITEMS  = 480;

    // Holds the reduced fractions still owed by the block, in order, and
    // works out each one from the operands as they are taken.
    class rau_result_book;
        t_rau_out pending_fractions[$];
        int       fail_count;
        int       noted_items;
        int       error_items;
        int       zero_items;

        function new();
            fail_count  = 0;
            noted_items = 0;
            error_items = 0;
            zero_items  = 0;
        endfunction

        function automatic t_rau_out reduce_fraction(t_rau_in item);
            longint            an, ad, bn, bd, top, bot;
            longint unsigned   mag_top, mag_bot, x, y, t;
            logic              neg;
            t_rau_out          r;
            r.res_num = '0;
            r.res_den = DEN_W'(1);
            r.err     = 1'b0;
            an = item.a_num;
            ad = item.a_den;
            bn = item.b_num;
            bd = item.b_den;
            if (ad == 0 || bd == 0 || (item.op == OP_DIV && bn == 0)) begin
                r.err = 1'b1;
                return r;
            end
            case (item.op)
                OP_ADD: begin
                    top = an * bd + bn * ad;
                    bot = ad * bd;
                end
                OP_SUB: begin
                    top = an * bd - bn * ad;
                    bot = ad * bd;
                end
                OP_MUL: begin
                    top = an * bn;
                    bot = ad * bd;
                end
                default: begin
                    top = an * bd;
                    bot = ad * bn;
                end
            endcase
            if (top == 0)
                return r;
            neg     = (top < 0) != (bot < 0);
            mag_top = (top < 0) ? -top : top;
            mag_bot = (bot < 0) ? -bot : bot;
            x = mag_top;
            y = mag_bot;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            mag_top = mag_top / x;
            mag_bot = mag_bot / x;
            r.res_num = neg ? NUM_W'(-mag_top) : NUM_W'(mag_top);
            r.res_den = DEN_W'(mag_bot);
            return r;
        endfunction

        function void note_operands(t_rau_in item);
            t_rau_out want;
            want = reduce_fraction(item);
            pending_fractions.push_back(want);
            noted_items++;
            if (want.err)
                error_items++;
            else if (want.res_num == 0)
                zero_items++;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            fail_count++;
        endtask

        task check_result(t_rau_out got);
            t_rau_out want;
            if (pending_fractions.size() == 0) begin
                report($sformatf("result %0d/%0d err %0b with nothing outstanding",
                                 got.res_num, got.res_den, got.err));
                return;
            end
            want = pending_fractions.pop_front();
            if (got.res_num !== want.res_num)
                report($sformatf("res_num %0d, expected %0d", got.res_num, want.res_num));
            if (got.res_den !== want.res_den)
                report($sformatf("res_den %0d, expected %0d", got.res_den, want.res_den));
            if (got.err !== want.err)
                report($sformatf("err %0b, expected %0b", got.err, want.err));
        endtask
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_rau_in  i_data;
    logic     busy;
    logic     o_valid;
    t_rau_out o_data;

    rau_result_book book;
    int             cycle_count;

    rational_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_data  (i_data),
        .busy    (busy),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, book.pending_fractions.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            book.check_result(o_data);
    end

    function automatic t_rau_in make_item(logic [1:0] op, int an, int ad, int bn, int bd);
        t_rau_in item;
        item.op    = op;
        item.a_num = OPND_W'(an);
        item.a_den = OPND_W'(ad);
        item.b_num = OPND_W'(bn);
        item.b_den = OPND_W'(bd);
        return item;
    endfunction

    // Extremes and small values turn up often enough to exercise the
    // sign handling and heavy reduction; a denominator is now and then zero.
    function automatic int pick_operand(bit as_den);
        int corner[6];
        corner = '{-32768, 32767, -1, 0, 1, -32767};
        if (as_den && $urandom_range(39) == 0)
            return 0;
        case ($urandom_range(9))
            0:       return corner[$urandom_range(5)];
            1, 2:    return int'($urandom_range(40)) - 20;
            3:       return int'($urandom_range(512)) - 256;
            default: return int'($urandom_range(65535));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item
    // has been taken, with start still high.
    task send_item(t_rau_in item, int idle_pct);
        bit taken;
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(negedge i_clk);
        end
        start  = 1'b1;
        i_data = item;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            if (taken)
                book.note_operands(item);
            @(negedge i_clk);
        end
    endtask

    task send_random(int count, int idle_pct);
        for (int n = 0; n < count; n++)
            send_item(make_item(2'($urandom_range(3)), pick_operand(1'b0), pick_operand(1'b1),
                                pick_operand(1'b0), pick_operand(1'b1)), idle_pct);
    endtask

    initial begin
        int phase_idle[3];
        phase_idle  = '{35, 59, 0};
        book        = new();
        start       = 1'b0;
        i_data      = '0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(make_item(OP_ADD, 1, 2, 1, 3), phase_idle[0]);
        send_item(make_item(OP_SUB, 1, 2, 1, 2), phase_idle[0]);
        send_item(make_item(OP_MUL, 2, 3, 3, 4), phase_idle[0]);
        send_item(make_item(OP_DIV, 1, 2, 3, 4), phase_idle[0]);
        // Zero denominators and a zero divisor all give 0/1 with the flag.
        send_item(make_item(OP_ADD, 1, 0, 1, 3), phase_idle[0]);
        send_item(make_item(OP_MUL, 1, 1, 5, 0), phase_idle[0]);
        send_item(make_item(OP_DIV, 3, 4, 0, 5), phase_idle[0]);
        send_item(make_item(OP_SUB, 0, 0, 0, 0), phase_idle[0]);
        send_item(make_item(OP_DIV, 7, 0, 0, 3), phase_idle[0]);
        send_item(make_item(OP_ADD, -32768, 32767, 32767, -32768), phase_idle[0]);
        send_item(make_item(OP_SUB, 32767, -32768, -32768, 32767), phase_idle[0]);
        send_item(make_item(OP_MUL, -32768, 1, -32768, 1), phase_idle[0]);
        send_item(make_item(OP_DIV, -32768, 1, 1, -32768), phase_idle[0]);
        send_item(make_item(OP_MUL, 32767, -32768, -32768, 32767), phase_idle[0]);
        send_item(make_item(OP_ADD, -1, -1, -1, -1), phase_idle[0]);
        send_item(make_item(OP_DIV, 0, -7, 5, 3), phase_idle[0]);
        send_item(make_item(OP_MUL, 0, 1, -32768, -32768), phase_idle[0]);
        send_item(make_item(OP_ADD, 32767, 32767, -32768, -32768), phase_idle[0]);
        send_item(make_item(OP_DIV, -32768, -32768, 32767, 32767), phase_idle[0]);
        send_item(make_item(OP_SUB, -5, -6, 7, -8), phase_idle[0]);
        send_item(make_item(OP_ADD, 6, -4, 0, 9), phase_idle[0]);
        send_item(make_item(OP_DIV, 1, 32767, 32767, 1), phase_idle[0]);
        send_item(make_item(OP_MUL, -1, 32767, 1, -32768), phase_idle[0]);
        send_item(make_item(OP_ADD, 0, -32768, 0, 32767), phase_idle[0]);
        send_item(make_item(OP_SUB, -32768, -1, 32767, 1), phase_idle[0]);

        for (int p = 0; p < 3; p++)
            send_random(RANDOM_ITEMS / 3, phase_idle[p]);
        start = 1'b0;

        while (book.pending_fractions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.pending_fractions.size() != 0)
            book.report("expected result never arrived");
        while (book.pending_fractions.size() != 0)
            void'(book.pending_fractions.pop_front());

        $display("Checked %0d operand items (%0d flagged, %0d zero results) over three",
                 book.noted_items, book.error_items, book.zero_items);
        $display("idle patterns in %0d cycles; %0d mismatches.", cycle_count,
                 book.fail_count);
        if (book.fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
